/* hdl/dmd_pkg.sv */
package dmd_pkg;

    localparam int YEAR_W       = 14;
    localparam int MONTH_W      = 4;
    localparam int DAY_W        = 5;
    localparam int DAYS_BACK_W  = 16;
    localparam int SER_W        = 22;
    localparam int COUNT_BITS_DEF = 16;

    localparam logic [YEAR_W-1:0]  YEAR_MAX   = YEAR_W'(9999);
    localparam logic [MONTH_W-1:0] MONTHS     = MONTH_W'(12);
    localparam logic [MONTH_W-1:0] MONTH_FEB  = MONTH_W'(2);

    localparam logic [SER_W-1:0] DAYS_400Y = SER_W'(146097);
    localparam logic [SER_W-1:0] DAYS_100Y = SER_W'(36524);
    localparam logic [SER_W-1:0] DAYS_4Y   = SER_W'(1461);
    localparam logic [SER_W-1:0] DAYS_1Y   = SER_W'(365);

    typedef enum logic [1:0] {
        LVL_400Y,
        LVL_100Y,
        LVL_4Y,
        LVL_1Y
    } t_lvl;

    typedef enum logic {
        ALU_ADD,
        ALU_SUB
    } t_alu_op;

    function automatic logic [YEAR_W-1:0] lvl_years(input t_lvl lvl);
        logic [YEAR_W-1:0] y;
        unique case (lvl)
            LVL_400Y: y = YEAR_W'(400);
            LVL_100Y: y = YEAR_W'(100);
            LVL_4Y:   y = YEAR_W'(4);
            LVL_1Y:   y = YEAR_W'(1);
            default:  y = YEAR_W'(1);
        endcase
        return y;
    endfunction

    function automatic logic [SER_W-1:0] lvl_days(input t_lvl lvl);
        logic [SER_W-1:0] d;
        unique case (lvl)
            LVL_400Y: d = DAYS_400Y;
            LVL_100Y: d = DAYS_100Y;
            LVL_4Y:   d = DAYS_4Y;
            LVL_1Y:   d = DAYS_1Y;
            default:  d = DAYS_1Y;
        endcase
        return d;
    endfunction

    function automatic logic [DAY_W-1:0] month_days(input logic [MONTH_W-1:0] m,
                                                    input logic leap);
        logic [DAY_W-1:0] d;
        unique case (m)
            4'd4, 4'd6, 4'd9, 4'd11: d = DAY_W'(30);
            MONTH_FEB:               d = leap ? DAY_W'(29) : DAY_W'(28);
            default:                 d = DAY_W'(31);
        endcase
        return d;
    endfunction

endpackage

/* hdl/dmd_alu.sv */
module dmd_alu
    import dmd_pkg::*;
(
    input  t_alu_op          i_op,
    input  logic [SER_W-1:0] i_a,
    input  logic [SER_W-1:0] i_b,
    output logic [SER_W-1:0] o_res,
    output logic             o_borrow
);

    logic [SER_W:0] w;

    always_comb begin
        unique case (i_op)
            ALU_ADD: w = {1'b0, i_a} + {1'b0, i_b};
            ALU_SUB: w = {1'b0, i_a} - {1'b0, i_b};
            default: w = {1'b0, i_a};
        endcase
    end

    assign o_res    = w[SER_W-1:0];
    assign o_borrow = w[SER_W];

endmodule

/* hdl/date_minus_days_top.sv */
// Gregorian date minus a count of days. One transaction at a time: the start
// date is turned into a day number counted from 0001-01-01, the count is
// subtracted, and the day number is turned back into year, month and day,
// all through one shared add/subtract unit that takes one step per cycle
// (a block of 400, 100, 4 or 1 years, or one month). The length of a
// transaction depends on the dates, and o_stall stays high until the
// result has been taken. Out-of-range start fields are clamped to the
// nearest valid date; a result before 0001-01-01 gives 0001-01-01 with
// o_underflow set.
module date_minus_days_top
    import dmd_pkg::*;
#(
    parameter int COUNT_BITS = COUNT_BITS_DEF
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_valid,
    output logic                   o_stall,
    input  logic [YEAR_W-1:0]      i_start_year,
    input  logic [MONTH_W-1:0]     i_start_month,
    input  logic [DAY_W-1:0]       i_start_day,
    input  logic [DAYS_BACK_W-1:0] i_days_back,
    output logic                   o_valid,
    input  logic                   i_stall,
    output logic [YEAR_W-1:0]      o_result_year,
    output logic [MONTH_W-1:0]     o_result_month,
    output logic [DAY_W-1:0]       o_result_day,
    output logic                   o_underflow
);

    localparam int UsedBits = (COUNT_BITS < DAYS_BACK_W) ? COUNT_BITS : DAYS_BACK_W;

    typedef enum logic [3:0] {
        S_IDLE,
        S_P_YEAR,
        S_CLAMP,
        S_P_MONTH,
        S_P_DAY,
        S_SUB,
        S_R_YEAR,
        S_R_MONTH,
        S_DONE
    } t_state;

    t_state               r_state;
    t_lvl                 r_lvl;
    logic [YEAR_W-1:0]    r_rem;
    logic [YEAR_W-1:0]    r_ry;
    logic [MONTH_W-1:0]   r_m;
    logic [MONTH_W-1:0]   r_mon;
    logic [DAY_W-1:0]     r_d;
    logic [DAY_W-1:0]     r_rd;
    logic                 r_uf;
    logic [SER_W-1:0]     r_ser;
    logic [UsedBits-1:0]  r_back;
    logic [1:0]           r_q100;
    logic [4:0]           r_q4;
    logic [1:0]           r_q1;

    t_alu_op              alu_op;
    logic [SER_W-1:0]     alu_b;
    logic [SER_W-1:0]     alu_res;
    logic                 alu_borrow;

    logic                 leap;
    logic                 lvl_open;
    logic [DAY_W-1:0]     mlen;
    logic [YEAR_W-1:0]    y_clamp;
    logic [MONTH_W-1:0]   m_clamp;
    logic [DAY_W-1:0]     d_clamp;

    // leap from the year counts inside the 400-year cycle
    assign leap = (r_q1 == 2'd3) && ((r_q4 != 5'd24) || (r_q100 == 2'd3));

    assign lvl_open = (r_lvl == LVL_400Y) || (r_lvl == LVL_4Y)
                   || ((r_lvl == LVL_100Y) && (r_q100 != 2'd3))
                   || ((r_lvl == LVL_1Y) && (r_q1 != 2'd3));

    assign mlen = month_days(r_m, leap);

    always_comb begin
        if (i_start_year == '0) begin
            y_clamp = YEAR_W'(1);
        end else if (i_start_year > YEAR_MAX) begin
            y_clamp = YEAR_MAX;
        end else begin
            y_clamp = i_start_year;
        end
        if (i_start_month == '0) begin
            m_clamp = MONTH_W'(1);
        end else if (i_start_month > MONTHS) begin
            m_clamp = MONTHS;
        end else begin
            m_clamp = i_start_month;
        end
        d_clamp = (i_start_day == '0) ? DAY_W'(1) : i_start_day;
    end

    always_comb begin
        alu_op = ALU_ADD;
        alu_b  = '0;
        unique case (r_state)
            S_P_YEAR: begin
                alu_op = ALU_ADD;
                alu_b  = lvl_days(r_lvl);
            end
            S_P_MONTH: begin
                alu_op = ALU_ADD;
                alu_b  = SER_W'(month_days(r_mon, leap));
            end
            S_P_DAY: begin
                alu_op = ALU_ADD;
                alu_b  = SER_W'(r_d - DAY_W'(1));
            end
            S_SUB: begin
                alu_op = ALU_SUB;
                alu_b  = SER_W'(r_back);
            end
            S_R_YEAR: begin
                alu_op = ALU_SUB;
                alu_b  = lvl_days(r_lvl);
            end
            S_R_MONTH: begin
                alu_op = ALU_SUB;
                alu_b  = SER_W'(month_days(r_mon, leap));
            end
            default: begin
                alu_op = ALU_ADD;
                alu_b  = '0;
            end
        endcase
    end

    dmd_alu u_alu (
        .i_op     (alu_op),
        .i_a      (r_ser),
        .i_b      (alu_b),
        .o_res    (alu_res),
        .o_borrow (alu_borrow)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            unique case (r_state)
                S_IDLE: begin
                    if (i_valid) begin
                        r_rem   <= y_clamp - YEAR_W'(1);
                        r_m     <= m_clamp;
                        r_d     <= d_clamp;
                        r_back  <= i_days_back[UsedBits-1:0];
                        r_ser   <= '0;
                        r_lvl   <= LVL_400Y;
                        r_q100  <= '0;
                        r_q4    <= '0;
                        r_q1    <= '0;
                        r_state <= S_P_YEAR;
                    end
                end
                S_P_YEAR: begin
                    if (r_rem >= lvl_years(r_lvl)) begin
                        r_rem <= r_rem - lvl_years(r_lvl);
                        r_ser <= alu_res;
                        unique case (r_lvl)
                            LVL_100Y: r_q100 <= r_q100 + 2'd1;
                            LVL_4Y:   r_q4   <= r_q4 + 5'd1;
                            LVL_1Y:   r_q1   <= r_q1 + 2'd1;
                            default: ;
                        endcase
                    end else if (r_lvl == LVL_1Y) begin
                        r_state <= S_CLAMP;
                    end else begin
                        r_lvl <= t_lvl'(r_lvl + 2'd1);
                    end
                end
                S_CLAMP: begin
                    if (r_d > mlen) begin
                        r_d <= mlen;
                    end
                    r_mon   <= MONTH_W'(1);
                    r_state <= S_P_MONTH;
                end
                S_P_MONTH: begin
                    if (r_mon < r_m) begin
                        r_ser <= alu_res;
                        r_mon <= r_mon + MONTH_W'(1);
                    end else begin
                        r_state <= S_P_DAY;
                    end
                end
                S_P_DAY: begin
                    r_ser   <= alu_res;
                    r_state <= S_SUB;
                end
                S_SUB: begin
                    r_ry <= YEAR_W'(1);
                    if (alu_borrow) begin
                        r_mon   <= MONTH_W'(1);
                        r_rd    <= DAY_W'(1);
                        r_uf    <= 1'b1;
                        r_state <= S_DONE;
                    end else begin
                        r_ser   <= alu_res;
                        r_uf    <= 1'b0;
                        r_lvl   <= LVL_400Y;
                        r_q100  <= '0;
                        r_q4    <= '0;
                        r_q1    <= '0;
                        r_state <= S_R_YEAR;
                    end
                end
                S_R_YEAR: begin
                    if (!alu_borrow && lvl_open) begin
                        r_ser <= alu_res;
                        r_ry  <= r_ry + lvl_years(r_lvl);
                        unique case (r_lvl)
                            LVL_100Y: r_q100 <= r_q100 + 2'd1;
                            LVL_4Y:   r_q4   <= r_q4 + 5'd1;
                            LVL_1Y:   r_q1   <= r_q1 + 2'd1;
                            default: ;
                        endcase
                    end else if (r_lvl == LVL_1Y) begin
                        r_mon   <= MONTH_W'(1);
                        r_state <= S_R_MONTH;
                    end else begin
                        r_lvl <= t_lvl'(r_lvl + 2'd1);
                    end
                end
                S_R_MONTH: begin
                    if ((r_mon < MONTHS) && !alu_borrow) begin
                        r_ser <= alu_res;
                        r_mon <= r_mon + MONTH_W'(1);
                    end else begin
                        r_rd    <= r_ser[DAY_W-1:0] + DAY_W'(1);
                        r_state <= S_DONE;
                    end
                end
                S_DONE: begin
                    if (!i_stall) begin
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_stall        = (r_state != S_IDLE);
    assign o_valid        = (r_state == S_DONE);
    assign o_result_year  = r_ry;
    assign o_result_month = r_mon;
    assign o_result_day   = r_rd;
    assign o_underflow    = r_uf;

endmodule

/* verif/tb_date_minus_days_top.sv */
module tb_date_minus_days_top;
    import dmd_pkg::*;

    localparam int COUNT_W      = COUNT_BITS_DEF;
    localparam int RANDOM_ITEMS = 1730;
    localparam int TAIL_ITEMS   = 150;
    localparam int HOLD_CYCLES  = 400;
    localparam int DRAIN_CYCLES = 200;
    localparam int CYCLE_LIMIT  = 1500000;

    localparam int unsigned DAYS_IN_MONTH [12] = '{31, 28, 31, 30, 31, 30,
                                                   31, 31, 30, 31, 30, 31};

    typedef struct packed {
        logic [YEAR_W-1:0]      year;
        logic [MONTH_W-1:0]     month;
        logic [DAY_W-1:0]       day;
        logic [DAYS_BACK_W-1:0] days_back;
    } t_request;

    typedef struct packed {
        logic [YEAR_W-1:0]  year;
        logic [MONTH_W-1:0] month;
        logic [DAY_W-1:0]   day;
        logic               underflow;
    } t_calendar_date;

    logic                   i_clk          = 1'b0;
    logic                   i_rst_n        = 1'b0;
    logic                   i_valid        = 1'b0;
    logic                   i_stall        = 1'b0;
    logic [YEAR_W-1:0]      i_start_year   = '0;
    logic [MONTH_W-1:0]     i_start_month  = '0;
    logic [DAY_W-1:0]       i_start_day    = '0;
    logic [DAYS_BACK_W-1:0] i_days_back    = '0;
    logic                   o_stall;
    logic                   o_valid;
    logic [YEAR_W-1:0]      o_result_year;
    logic [MONTH_W-1:0]     o_result_month;
    logic [DAY_W-1:0]       o_result_day;
    logic                   o_underflow;

    t_request       request_q[$];
    t_calendar_date expected_dates_q[$];
    int             requests_total = 0;
    int             requests_taken = 0;
    int             dates_seen     = 0;
    int             mismatch_cnt   = 0;
    int             cycle_cnt      = 0;
    bit             offer_taken    = 1'b0;
    int             send_gap       = 0;
    int             stall_left     = 0;
    int             hold_left      = 0;
    bit             hold_done      = 1'b0;

    date_minus_days_top #(
        .COUNT_BITS(COUNT_W)
    ) dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (i_valid),
        .o_stall       (o_stall),
        .i_start_year  (i_start_year),
        .i_start_month (i_start_month),
        .i_start_day   (i_start_day),
        .i_days_back   (i_days_back),
        .o_valid       (o_valid),
        .i_stall       (i_stall),
        .o_result_year (o_result_year),
        .o_result_month(o_result_month),
        .o_result_day  (o_result_day),
        .o_underflow   (o_underflow)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    function automatic bit is_leap_year(input int unsigned yr);
        return ((yr % 4) == 0 && (yr % 100) != 0) || (yr % 400) == 0;
    endfunction

    function automatic int unsigned month_length(input int unsigned yr, input int unsigned mo);
        int unsigned len;
        len = DAYS_IN_MONTH[(mo - 1) % 12];
        if (mo == 2 && is_leap_year(yr)) begin
            len = 29;
        end
        return len;
    endfunction

    // day number from 0001-01-01, subtract, then walk 400/100/4/1 years and months
    function automatic t_calendar_date date_back(input t_request rq);
        int unsigned yr, mo, dy, cnt, ser, prev, q, k;
        t_calendar_date r;
        yr  = rq.year;
        mo  = rq.month;
        dy  = rq.day;
        cnt = rq.days_back & ((32'd1 << COUNT_W) - 1);
        if (yr < 1) yr = 1;
        if (yr > 9999) yr = 9999;
        if (mo < 1) mo = 1;
        if (mo > 12) mo = 12;
        if (dy < 1) dy = 1;
        if (dy > month_length(yr, mo)) dy = month_length(yr, mo);
        prev = yr - 1;
        ser = 365 * prev + prev / 4 - prev / 100 + prev / 400;
        for (k = 1; k < mo; k++) begin
            ser += month_length(yr, k);
        end
        ser += dy - 1;
        if (cnt > ser) begin
            r = '{year: YEAR_W'(1), month: MONTH_W'(1), day: DAY_W'(1), underflow: 1'b1};
        end else begin
            ser -= cnt;
            yr = 1 + 400 * (ser / 146097);
            ser = ser % 146097;
            q = ser / 36524;
            if (q > 3) q = 3;
            ser -= q * 36524;
            yr += 100 * q;
            yr += 4 * (ser / 1461);
            ser = ser % 1461;
            q = ser / 365;
            if (q > 3) q = 3;
            ser -= q * 365;
            yr += q;
            mo = 1;
            while (mo < 12 && ser >= month_length(yr, mo)) begin
                ser -= month_length(yr, mo);
                mo++;
            end
            r.year      = YEAR_W'(yr);
            r.month     = MONTH_W'(mo);
            r.day       = DAY_W'(ser + 1);
            r.underflow = 1'b0;
        end
        return r;
    endfunction

    function automatic t_request random_request();
        t_request rq;
        int unsigned pick, yr, mo, len;
        pick = $urandom_range(0, 99);
        if (pick < 8) begin
            // raw field values, clamping paths included
            rq.year      = YEAR_W'($urandom);
            rq.month     = MONTH_W'($urandom);
            rq.day       = DAY_W'($urandom);
            rq.days_back = DAYS_BACK_W'($urandom);
            return rq;
        end
        if (pick < 35) begin
            yr = $urandom_range(1, 9999);
        end else if (pick < 50) begin
            yr = $urandom_range(1, 200);
        end else if (pick < 60) begin
            yr = $urandom_range(9800, 9999);
        end else if (pick < 75) begin
            yr = 100 * $urandom_range(1, 99) + $urandom_range(0, 1);
        end else begin
            yr = $urandom_range(1, 9999);
        end
        mo  = $urandom_range(1, 12);
        len = month_length(yr, mo);
        rq.year  = YEAR_W'(yr);
        rq.month = MONTH_W'(mo);
        rq.day   = DAY_W'(($urandom_range(0, 3) == 0) ? len : $urandom_range(1, len));
        pick = $urandom_range(0, 3);
        if (pick < 2) begin
            rq.days_back = DAYS_BACK_W'($urandom);
        end else if (pick == 2) begin
            rq.days_back = DAYS_BACK_W'($urandom_range(0, 62));
        end else begin
            rq.days_back = DAYS_BACK_W'($urandom_range(300, 1500));
        end
        return rq;
    endfunction

    task automatic add_date(input int unsigned yr, input int unsigned mo,
                            input int unsigned dy, input int unsigned back);
        request_q.push_back('{year: YEAR_W'(yr), month: MONTH_W'(mo), day: DAY_W'(dy),
                              days_back: DAYS_BACK_W'(back)});
    endtask

    task automatic report_mismatch(input string what, input int got, input int want);
        $display("mismatch at cycle %0d: %s got %0d expected %0d", cycle_cnt, what, got, want);
        mismatch_cnt++;
    endtask

    // sender
    always @(negedge i_clk) begin : driver
        t_request nxt;
        if (i_rst_n && (!i_valid || offer_taken)) begin
            offer_taken = 1'b0;
            if (send_gap > 0) begin
                send_gap--;
                i_valid <= 1'b0;
            end else if (request_q.size() >= TAIL_ITEMS && (requests_taken % 300) < 200
                         && $urandom_range(0, 5) == 0) begin
                send_gap = $urandom_range(0, 13);
                i_valid <= 1'b0;
            end else if (request_q.size() > 0) begin
                nxt = request_q.pop_front();
                i_start_year  <= nxt.year;
                i_start_month <= nxt.month;
                i_start_day   <= nxt.day;
                i_days_back   <= nxt.days_back;
                i_valid       <= 1'b1;
            end else begin
                i_valid <= 1'b0;
            end
        end
    end

    // receiver, with one long hold-off so the block backs up
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            i_stall <= 1'b0;
        end else if (hold_left > 0) begin
            hold_left--;
            i_stall <= 1'b1;
        end else if (!hold_done && dates_seen >= 300) begin
            hold_done = 1'b1;
            hold_left = HOLD_CYCLES - 1;
            i_stall <= 1'b1;
        end else if (stall_left > 0) begin
            stall_left--;
            i_stall <= 1'b1;
        end else if (request_q.size() >= TAIL_ITEMS && (dates_seen % 300) < 200
                     && $urandom_range(0, 7) == 0) begin
            stall_left = $urandom_range(0, 13);
            i_stall <= 1'b1;
        end else begin
            i_stall <= 1'b0;
        end
    end

    always @(posedge i_clk) begin : monitor
        t_request       rq;
        t_calendar_date want;
        if (i_rst_n && i_valid && !o_stall) begin
            rq = '{year: i_start_year, month: i_start_month, day: i_start_day,
                   days_back: i_days_back};
            expected_dates_q.push_back(date_back(rq));
            offer_taken = 1'b1;
            requests_taken++;
        end
        if (i_rst_n && o_valid && !i_stall) begin
            dates_seen++;
            if (expected_dates_q.size() == 0) begin
                report_mismatch("transaction with nothing expected, year", o_result_year, 0);
            end else begin
                want = expected_dates_q.pop_front();
                if (o_result_year !== want.year)
                    report_mismatch("year", o_result_year, want.year);
                if (o_result_month !== want.month)
                    report_mismatch("month", o_result_month, want.month);
                if (o_result_day !== want.day)
                    report_mismatch("day", o_result_day, want.day);
                if (o_underflow !== want.underflow)
                    report_mismatch("underflow", o_underflow, want.underflow);
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_cnt++;
        if (cycle_cnt > CYCLE_LIMIT) begin
            $display("simulation failed");
            $finish;
        end
    end

    initial begin
        add_date(1, 1, 1, 0);
        add_date(1, 1, 1, 1);
        add_date(1, 1, 2, 1);
        add_date(1, 1, 1, 65535);
        add_date(9999, 12, 31, 0);
        add_date(9999, 12, 31, 65535);
        add_date(0, 6, 15, 10);
        add_date(16383, 15, 31, 65535);
        add_date(2023, 0, 0, 5);
        add_date(2023, 13, 20, 5);
        add_date(2000, 2, 31, 0);
        add_date(1900, 2, 30, 0);
        add_date(2023, 4, 31, 0);
        add_date(2000, 3, 1, 1);
        add_date(1900, 3, 1, 1);
        add_date(2024, 3, 1, 1);
        add_date(2001, 1, 1, 1);
        add_date(2, 1, 1, 365);
        add_date(2, 1, 1, 366);
        add_date(401, 1, 1, 1);
        add_date(2001, 1, 1, 366);
        add_date(180, 5, 17, 65535);
        add_date(8191, 7, 16, 32768);
        for (int n = 0; n < RANDOM_ITEMS; n++) begin
            request_q.push_back(random_request());
        end
        requests_total = request_q.size();
        repeat (10) @(negedge i_clk);
        i_rst_n <= 1'b1;
        while (requests_taken < requests_total || expected_dates_q.size() > 0) begin
            @(negedge i_clk);
        end
        repeat (DRAIN_CYCLES) @(negedge i_clk);
        if (mismatch_cnt == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule
